// ===== sv/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

	localparam int DEFAULT_CAPACITY = 128;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [VALUE_W-1:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [VALUE_W-1:0]      value;
	} entry_t;

endpackage
`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
`default_nettype none
// An insert steps through the m entries that move to make room, m maybe zero, before its result;
// an extract reads the head entry first; a refused insert or empty extract goes straight to its result.
// One request is in work at a time; the next is accepted from the cycle in which out_valid rises,
// and the result, and so the next request, waits while an earlier result has not been taken.
// An insert walks the ring memory one entry a cycle from the tail toward its slot.
// Asynchronous active-low reset empties the queue; memory contents are not cleared.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            req_type,
	input  wire logic signed [spq_pkg::KEY_W-1:0] item_key,
	input  wire logic [spq_pkg::VALUE_W-1:0]     item_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           status,
	output logic [spq_pkg::VALUE_W-1:0]          out_value,
	output logic [spq_pkg::COUNT_W-1:0]          entry_count
);
	import spq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_CMP = 3'd1;
	localparam logic [2:0] S_INS_WR  = 3'd2;
	localparam logic [2:0] S_EXT_RD  = 3'd3;
	localparam logic [2:0] S_FIN     = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] idx_q;
	entry_t        new_q;

	logic [1:0]         pend_status_q;
	logic [VALUE_W-1:0] pend_value_q;
	logic [CW-1:0]      pend_count_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	entry_t        mem_wr_data;
	logic [AW-1:0] mem_rd_addr;
	entry_t        mem_rd_data;

	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] cur_inc;
	logic [AW-1:0] cur_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;
	logic          in_fire;
	logic          out_free;
	logic          shift_up;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign tail_sum  = {1'b0, head_q} + {1'b0, AW'(count_q - CW'(1))};
	assign tail_addr = (tail_sum >= (AW+1)'(CAPACITY)) ?
		AW'(tail_sum - (AW+1)'(CAPACITY)) : tail_sum[AW-1:0];

	assign cur_inc  = (cur_q == LAST_ADDR) ? '0 : cur_q + AW'(1);
	assign cur_dec  = (cur_q == '0) ? LAST_ADDR : cur_q - AW'(1);
	assign head_inc = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? LAST_ADDR : head_q - AW'(1);

	assign shift_up = (mem_rd_data.key >= new_q.key);

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = cur_inc;
		mem_wr_data = new_q;
		mem_rd_addr = cur_dec;
		unique case (state_q)
			S_IDLE: begin
				mem_rd_addr = (req_type == REQ_EXTRACT) ? head_q : tail_addr;
			end
			S_INS_CMP: begin
				mem_wr_en = 1'b1;
				if (shift_up) begin
					mem_wr_data = mem_rd_data;
				end
			end
			S_INS_WR: begin
				mem_wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	spq_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (req_type == REQ_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q + CW'(1);
								if (count_q == '0) begin
									state_q <= S_INS_WR;
								end else begin
									state_q <= S_INS_CMP;
								end
							end
						end else begin
							if (count_q == '0) begin
								state_q <= S_FIN;
							end else begin
								head_q  <= head_inc;
								count_q <= count_q - CW'(1);
								state_q <= S_EXT_RD;
							end
						end
					end
				end
				S_INS_CMP: begin
					if (!shift_up) begin
						state_q <= S_FIN;
					end else if (idx_q == '0) begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					state_q <= S_FIN;
				end
				S_EXT_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				new_q.key   <= item_key;
				new_q.value <= item_value;
				idx_q       <= AW'(count_q - CW'(1));
				if (count_q == '0) begin
					cur_q <= head_dec;
				end else begin
					cur_q <= tail_addr;
				end
				pend_value_q <= '0;
				if (req_type == REQ_INSERT) begin
					if (count_q == CW'(CAPACITY)) begin
						pend_status_q <= ST_FULL;
						pend_count_q  <= count_q;
					end else begin
						pend_status_q <= ST_OK;
						pend_count_q  <= count_q + CW'(1);
					end
				end else begin
					if (count_q == '0) begin
						pend_status_q <= ST_EMPTY;
						pend_value_q  <= NEG_INF_BITS;
						pend_count_q  <= count_q;
					end else begin
						pend_status_q <= ST_OK;
						pend_count_q  <= count_q - CW'(1);
					end
				end
			end
			S_INS_CMP: begin
				if (shift_up) begin
					cur_q <= cur_dec;
					idx_q <= idx_q - AW'(1);
				end
			end
			S_EXT_RD: begin
				pend_value_q <= mem_rd_data.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			status_q      <= pend_status_q;
			out_value_q   <= pend_value_q;
			entry_count_q <= COUNT_W'(pend_count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_value   = out_value_q;
	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

// ===== sv/spq_store.sv =====
`default_nettype none
module spq_store #(
	parameter int DEPTH = spq_pkg::DEFAULT_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire spq_pkg::entry_t wr_data,
	input  wire logic [AW-1:0]   rd_addr,
	output spq_pkg::entry_t      rd_data
);
	import spq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_data_s1;

endmodule
`default_nettype wire
